[design/layer_blend_weight_store_core_macros.svh]
// assertion helpers for the layer blend weight store
`ifndef LAYER_BLEND_WEIGHT_STORE_CORE_MACROS_SVH
`define LAYER_BLEND_WEIGHT_STORE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define LBW_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lbw check failed");
// next-cycle implication
`define LBW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbw check failed");
`else
`define LBW_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LBW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[design/lbw_pkg.sv]
`default_nettype none

package lbw_pkg;

   // field widths
   localparam int OP_W    = 2;
   localparam int COORD_W = 6;
   localparam int LAYER_W = 3;
   localparam int ALPHA_W = 8;
   localparam int COUNT_W = 4;

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

   // fixed point: scale is Q1.16
   localparam int SCALE_W = 17;
   localparam logic [SCALE_W-1:0] SCALE_ONE    = 17'd65536;
   localparam logic [SCALE_W-1:0] SCALE_THRESH = 17'd655;

   // shared multiplier widths
   localparam int MUL_A_W = 25;
   localparam int PROD_W  = MUL_A_W + SCALE_W;
   localparam int BIAS_W  = 25;
   localparam int FIX_W   = 26;
   localparam int QUO_W   = PROD_W - 24;

   // 2^24 / 255 rounded down, for division by 255
   localparam logic [SCALE_W-1:0] RECIP_255 = 17'd65793;
   localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

   // operand choice for the shared multiplier
   typedef enum logic [1:0] {
      MUL_ALPHA_SCALE,
      MUL_COMPL_SCALE,
      MUL_RECIP,
      MUL_SCALE_MAX
   } mul_sel_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        mul_en;
      logic        bias_en;
   } unit_ctl_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_RD_ADDR,
      ST_RD_EMIT,
      ST_Q_EMPTY,
      ST_Q_ADDR,
      ST_Q_MULW,
      ST_Q_MULS,
      ST_Q_BIAS,
      ST_Q_RECIP,
      ST_Q_FIX,
      ST_Q_EMIT,
      ST_L_MUL,
      ST_L_EMIT
   } state_type;

endpackage

`default_nettype wire

[design/lbw_alpha_mem.sv]
`default_nettype none

module lbw_alpha_mem #(
   parameter int DEPTH  = 32768,
   parameter int ADDR_W = 15
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [lbw_pkg::ALPHA_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [lbw_pkg::ALPHA_W-1:0] rd_data
);
   import lbw_pkg::*;

   logic [ALPHA_W-1:0] mem [DEPTH];
   logic [ALPHA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[design/lbw_blend_unit.sv]
`default_nettype none

module lbw_blend_unit (
   input  logic                        clock,
   input  lbw_pkg::unit_ctl_type       ctl,
   input  logic [lbw_pkg::ALPHA_W-1:0] alpha,
   input  logic [lbw_pkg::SCALE_W-1:0] scale,
   output logic [lbw_pkg::ALPHA_W-1:0] weight,
   output logic [lbw_pkg::SCALE_W-1:0] scale_next
);
   import lbw_pkg::*;

   logic [MUL_A_W-1:0] op_a;
   logic [SCALE_W-1:0] op_b;
   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W-1:0]  prod_in;
   logic [BIAS_W-1:0]  bias_ff;
   logic [BIAS_W-1:0]  bias_in;
   logic [24:0]        wsum;
   logic [QUO_W-1:0]   quo;
   logic [FIX_W-1:0]   quo_x255;
   logic [FIX_W-1:0]   rem;

   // operand select for the one multiplier
   always_comb begin
      unique case (ctl.mul_sel)
         MUL_ALPHA_SCALE: begin
            op_a = MUL_A_W'(alpha);
            op_b = scale;
         end
         MUL_COMPL_SCALE: begin
            op_a = MUL_A_W'(ALPHA_MAX - alpha);
            op_b = scale;
         end
         MUL_RECIP: begin
            op_a = bias_ff;
            op_b = RECIP_255;
         end
         MUL_SCALE_MAX: begin
            op_a = MUL_A_W'(ALPHA_MAX);
            op_b = scale;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   // rounding bias ahead of the divide by 255
   assign bias_in = prod_ff[BIAS_W-1:0] + BIAS_W'(127);

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctl.bias_en) begin
         bias_ff <= bias_in;
      end
   end

   // weight = (product + 0.5) >> 16
   assign wsum   = 25'(prod_ff[23:0]) + 25'd32768;
   assign weight = wsum[23:16];

   // reciprocal quotient is exact or one short: fix with one compare
   assign quo        = prod_ff[PROD_W-1:24];
   assign quo_x255   = {FIX_W'(quo)} << 8;
   assign rem        = FIX_W'(bias_ff) - (quo_x255 - FIX_W'(quo));
   assign scale_next = (rem >= FIX_W'(ALPHA_MAX)) ? SCALE_W'(quo + QUO_W'(1))
                                                  : SCALE_W'(quo);

endmodule

`default_nettype wire

[design/layer_blend_weight_store_core.sv]
`default_nettype none
`include "layer_blend_weight_store_core_macros.svh"

// Per-layer 8-bit alpha maps with front-to-back blend weight queries. After
// reset the alpha memory is swept to zero one byte a cycle, with req_stall
// high; csr writes are taken at any time. One item is worked on at a time: a
// write takes its write step, a read an address and an emit step, a query
// with no layers in use an emit step, and any other query the address, weight
// multiply, scale multiply, bias, reciprocal, fix and emit steps for each layer
// walked, and a multiply and an emit step more when the leftover goes to layer
// 0. The walk is set by the single memory read port and one shared multiplier
// that forms the weight, the scale product and the 1/255 reciprocal in turn. A
// waiting result sits in the output register while the next item is accepted;
// a stalled output holds the sequencer in its emit step.
module layer_blend_weight_store_core #(
   parameter int LAYERS   = 8,
   parameter int MAP_SIZE = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [lbw_pkg::OP_W-1:0]    req_operation,
   input  logic [lbw_pkg::COORD_W-1:0] req_pos_x,
   input  logic [lbw_pkg::COORD_W-1:0] req_pos_y,
   input  logic [lbw_pkg::LAYER_W-1:0] req_layer_sel,
   input  logic [lbw_pkg::ALPHA_W-1:0] req_alpha_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [lbw_pkg::LAYER_W-1:0] rsp_out_layer,
   output logic [lbw_pkg::ALPHA_W-1:0] rsp_out_value,
   output logic [lbw_pkg::COUNT_W-1:0] rsp_visible_count,
   output logic                        rsp_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lbw_pkg::COUNT_W-1:0] csr_layer_count
);
   import lbw_pkg::*;

   localparam int DEPTH  = LAYERS * MAP_SIZE * MAP_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int MAX_N  = (LAYERS < 8) ? LAYERS : 8;
   localparam logic [COUNT_W-1:0] MAX_N_C  = COUNT_W'(MAX_N);
   localparam logic [ADDR_W-1:0]  PLANE    = ADDR_W'(MAP_SIZE * MAP_SIZE);
   localparam logic [ADDR_W-1:0]  ROW      = ADDR_W'(MAP_SIZE);
   localparam logic [ADDR_W-1:0]  CLR_LAST = ADDR_W'(DEPTH - 1);

   state_type state_ff, state_in;

   logic [COUNT_W-1:0] lc_ff, lc_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [COORD_W-1:0] x_ff, x_in;
   logic [COORD_W-1:0] y_ff, y_in;
   logic [LAYER_W-1:0] sel_ff, sel_in;
   logic [ALPHA_W-1:0] wdata_ff, wdata_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic [LAYER_W-1:0] walk_ff, walk_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [ALPHA_W-1:0] alpha_ff, alpha_in;
   logic [ALPHA_W-1:0] weight_ff, weight_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [LAYER_W-1:0] rsp_layer_ff;
   logic [ALPHA_W-1:0] rsp_value_ff;
   logic [COUNT_W-1:0] rsp_vis_ff;
   logic               rsp_last_ff;

   logic [COUNT_W-1:0] n_act;
   logic [COORD_W-1:0] x_mod, y_mod;
   logic               accept;
   logic               sel_in_use;
   logic               rsp_free;
   logic               q_last;
   logic [LAYER_W-1:0] addr_layer;
   logic [ADDR_W-1:0]  cell_addr;

   logic               mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]  mem_addr;
   logic [ALPHA_W-1:0] mem_wr_data, mem_rd_data;

   unit_ctl_type       unit_ctl;
   logic [ALPHA_W-1:0] unit_alpha;
   logic [ALPHA_W-1:0] unit_weight;
   logic [SCALE_W-1:0] unit_scale_next;

   logic               emit_en;
   logic [LAYER_W-1:0] emit_layer;
   logic [ALPHA_W-1:0] emit_value;
   logic [COUNT_W-1:0] emit_vis;
   logic               emit_last;

   // layers in use, clamped
   assign n_act = (lc_ff > MAX_N_C) ? MAX_N_C : lc_ff;

   // coordinate wrap through a small constant table
   always_comb begin
      x_mod = '0;
      y_mod = '0;
      for (int i = 0; i < (1 << COORD_W); i++) begin
         if (req_pos_x == COORD_W'(i)) begin
            x_mod = COORD_W'(i % MAP_SIZE);
         end
         if (req_pos_y == COORD_W'(i)) begin
            y_mod = COORD_W'(i % MAP_SIZE);
         end
      end
   end

   assign accept     = req_valid && !req_stall;
   assign sel_in_use = {1'b0, sel_ff} < n_act;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign q_last     = scale_ff <= SCALE_THRESH;

   // memory address of one layer at the latched pixel
   assign addr_layer = (state_ff == ST_Q_ADDR) ? walk_ff : sel_ff;
   assign cell_addr  = ADDR_W'(addr_layer) * PLANE + ADDR_W'(y_ff) * ROW + ADDR_W'(x_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_operation)
                  OP_WRITE: state_in = ST_WRITE;
                  OP_READ:  state_in = ST_RD_ADDR;
                  OP_QUERY: begin
                     if (n_act == '0) begin
                        state_in = ST_Q_EMPTY;
                     end else if (n_act == COUNT_W'(1)) begin
                        state_in = ST_L_MUL;
                     end else begin
                        state_in = ST_Q_ADDR;
                     end
                  end
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_WRITE:   state_in = ST_IDLE;
         ST_RD_ADDR: state_in = ST_RD_EMIT;
         ST_RD_EMIT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         ST_Q_EMPTY: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         ST_Q_ADDR:  state_in = ST_Q_MULW;
         ST_Q_MULW:  state_in = ST_Q_MULS;
         ST_Q_MULS:  state_in = ST_Q_BIAS;
         ST_Q_BIAS:  state_in = ST_Q_RECIP;
         ST_Q_RECIP: state_in = ST_Q_FIX;
         ST_Q_FIX:   state_in = ST_Q_EMIT;
         ST_Q_EMIT: begin
            if (rsp_free) begin
               if (q_last) begin
                  state_in = ST_IDLE;
               end else if (walk_ff == LAYER_W'(1)) begin
                  state_in = ST_L_MUL;
               end else begin
                  state_in = ST_Q_ADDR;
               end
            end
         end
         ST_L_MUL:   state_in = ST_L_EMIT;
         ST_L_EMIT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:    state_in = ST_CLEAR;
      endcase
   end

   // state outputs: memory, shared unit, result emit
   always_comb begin
      req_stall        = 1'b1;
      mem_wr_en        = 1'b0;
      mem_rd_en        = 1'b0;
      mem_addr         = cell_addr;
      mem_wr_data      = wdata_ff;
      unit_ctl.mul_sel = MUL_ALPHA_SCALE;
      unit_ctl.mul_en  = 1'b0;
      unit_ctl.bias_en = 1'b0;
      unit_alpha       = alpha_ff;
      emit_en          = 1'b0;
      emit_layer       = '0;
      emit_value       = '0;
      emit_vis         = '0;
      emit_last        = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_addr    = clr_ff;
            mem_wr_data = '0;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_WRITE: begin
            mem_wr_en = sel_in_use;
         end
         ST_RD_ADDR: begin
            mem_rd_en = sel_in_use;
         end
         ST_RD_EMIT: begin
            emit_en    = rsp_free;
            emit_layer = sel_ff;
            emit_value = sel_in_use ? mem_rd_data : '0;
            emit_last  = 1'b1;
         end
         ST_Q_EMPTY: begin
            emit_en   = rsp_free;
            emit_last = 1'b1;
         end
         ST_Q_ADDR: begin
            mem_rd_en = 1'b1;
         end
         ST_Q_MULW: begin
            unit_alpha       = mem_rd_data;
            unit_ctl.mul_sel = MUL_ALPHA_SCALE;
            unit_ctl.mul_en  = 1'b1;
         end
         ST_Q_MULS: begin
            unit_ctl.mul_sel = MUL_COMPL_SCALE;
            unit_ctl.mul_en  = 1'b1;
         end
         ST_Q_BIAS: begin
            unit_ctl.bias_en = 1'b1;
         end
         ST_Q_RECIP: begin
            unit_ctl.mul_sel = MUL_RECIP;
            unit_ctl.mul_en  = 1'b1;
         end
         ST_Q_FIX: begin
         end
         ST_Q_EMIT: begin
            emit_en    = rsp_free;
            emit_layer = walk_ff;
            emit_value = weight_ff;
            emit_vis   = q_last ? (count_ff + COUNT_W'(1)) : '0;
            emit_last  = q_last;
         end
         ST_L_MUL: begin
            unit_ctl.mul_sel = MUL_SCALE_MAX;
            unit_ctl.mul_en  = 1'b1;
         end
         ST_L_EMIT: begin
            emit_en    = rsp_free;
            emit_value = unit_weight;
            emit_vis   = count_ff + COUNT_W'(1);
            emit_last  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      lc_in        = lc_ff;
      clr_in       = clr_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      sel_in       = sel_ff;
      wdata_in     = wdata_ff;
      scale_in     = scale_ff;
      walk_in      = walk_ff;
      count_in     = count_ff;
      alpha_in     = alpha_ff;
      weight_in    = weight_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         lc_in = csr_layer_count;
      end
      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + ADDR_W'(1);
      end
      // latch the item and start a walk
      if (accept) begin
         x_in     = x_mod;
         y_in     = y_mod;
         sel_in   = req_layer_sel;
         wdata_in = req_alpha_in;
         scale_in = SCALE_ONE;
         walk_in  = LAYER_W'(n_act - COUNT_W'(1));
         count_in = '0;
      end
      if (state_ff == ST_Q_MULW) begin
         alpha_in = mem_rd_data;
      end
      if (state_ff == ST_Q_MULS) begin
         weight_in = unit_weight;
      end
      if (state_ff == ST_Q_FIX) begin
         scale_in = unit_scale_next;
      end
      // one result leaves for the output register
      if (emit_en) begin
         rsp_valid_in = 1'b1;
         count_in     = count_ff + COUNT_W'(1);
         if (state_ff == ST_Q_EMIT) begin
            walk_in = walk_ff - LAYER_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         lc_ff        <= COUNT_W'(1);
         rsp_valid_ff <= 1'b0;
         scale_ff     <= SCALE_ONE;
         walk_ff      <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         lc_ff        <= lc_in;
         rsp_valid_ff <= rsp_valid_in;
         scale_ff     <= scale_in;
         walk_ff      <= walk_in;
         count_ff     <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      y_ff      <= y_in;
      sel_ff    <= sel_in;
      wdata_ff  <= wdata_in;
      alpha_ff  <= alpha_in;
      weight_ff <= weight_in;
      if (emit_en) begin
         rsp_layer_ff <= emit_layer;
         rsp_value_ff <= emit_value;
         rsp_vis_ff   <= emit_vis;
         rsp_last_ff  <= emit_last;
      end
   end

   lbw_alpha_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_addr),
      .rd_data (mem_rd_data)
   );

   lbw_blend_unit u_unit (
      .clock      (clock),
      .ctl        (unit_ctl),
      .alpha      (unit_alpha),
      .scale      (scale_ff),
      .weight     (unit_weight),
      .scale_next (unit_scale_next)
   );

   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_layer     = rsp_layer_ff;
   assign rsp_out_value     = rsp_value_ff;
   assign rsp_visible_count = rsp_vis_ff;
   assign rsp_last          = rsp_last_ff;

   // checks
   `LBW_ASSERT_IMPL(a_walk_range, clock, reset, state_ff == ST_Q_ADDR,
                    walk_ff != '0 && {1'b0, walk_ff} < n_act)
   `LBW_ASSERT_IMPL(a_scale_max, clock, reset, state_ff != ST_CLEAR, scale_ff <= SCALE_ONE)
   `LBW_ASSERT_NEXT(a_last_idle, clock, reset, emit_en && emit_last, state_ff == ST_IDLE)
   `LBW_ASSERT_IMPL(a_vis_last, clock, reset, rsp_valid_ff && rsp_vis_ff != '0,
                    rsp_last_ff)

endmodule

`default_nettype wire

[tb/layer_blend_weight_checker.sv]
`default_nettype none

module layer_blend_weight_checker #(
   parameter int LAYERS   = 8,
   parameter int MAP_SIZE = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [lbw_pkg::OP_W-1:0]    req_operation,
   input  logic [lbw_pkg::COORD_W-1:0] req_pos_x,
   input  logic [lbw_pkg::COORD_W-1:0] req_pos_y,
   input  logic [lbw_pkg::LAYER_W-1:0] req_layer_sel,
   input  logic [lbw_pkg::ALPHA_W-1:0] req_alpha_in,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [lbw_pkg::LAYER_W-1:0] rsp_out_layer,
   input  logic [lbw_pkg::ALPHA_W-1:0] rsp_out_value,
   input  logic [lbw_pkg::COUNT_W-1:0] rsp_visible_count,
   input  logic                        rsp_last,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [lbw_pkg::COUNT_W-1:0] csr_layer_count,
   output int                          error_total,
   output int                          answers_due
);
   import lbw_pkg::*;

   typedef struct packed {
      logic [LAYER_W-1:0] layer;
      logic [ALPHA_W-1:0] value;
      logic [COUNT_W-1:0] visible;
      logic               is_last;
   } answer_type;

   // mirror of the alpha maps and the layer count register
   logic [ALPHA_W-1:0] alpha_mirror [LAYERS*MAP_SIZE*MAP_SIZE];
   logic [COUNT_W-1:0] count_mirror;
   answer_type         answer_queue [$];
   int                 errors_seen = 0;

   function automatic int mirror_addr(input int layer, input int px, input int py);
      return (layer * MAP_SIZE + (py % MAP_SIZE)) * MAP_SIZE + (px % MAP_SIZE);
   endfunction

   // apply one item to the mirror and queue the answers it causes
   task automatic blend_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] px,
                             input logic [COORD_W-1:0] py, input logic [LAYER_W-1:0] sel,
                             input logic [ALPHA_W-1:0] alpha);
      int unsigned n, scale, a, w;
      int          layer, count, k;
      answer_type  walk [8];
      answer_type  ans;
      n = 32'(count_mirror);
      if (n > LAYERS) n = LAYERS;
      if (n > 8) n = 8;
      count = 0;
      case (op)
         OP_WRITE: begin
            if (32'(sel) < n)
               alpha_mirror[mirror_addr(int'(sel), int'(px), int'(py))] = alpha;
         end
         OP_READ: begin
            ans.layer   = sel;
            ans.value   = (32'(sel) < n) ?
                          alpha_mirror[mirror_addr(int'(sel), int'(px), int'(py))] : '0;
            ans.visible = '0;
            ans.is_last = 1'b1;
            answer_queue = {answer_queue, ans};
         end
         OP_QUERY: begin
            if (n == 0) begin
               ans = '{layer: '0, value: '0, visible: '0, is_last: 1'b1};
               answer_queue = {answer_queue, ans};
            end else begin
               // front to back walk, top layer first
               scale = 32'(SCALE_ONE);
               layer = n - 1;
               while (layer > 0 && scale > SCALE_THRESH) begin
                  a = 32'(alpha_mirror[mirror_addr(layer, int'(px), int'(py))]);
                  w = (a * scale + 32768) >> 16;
                  walk[count] = '{layer: LAYER_W'(layer), value: ALPHA_W'(w),
                                  visible: '0, is_last: 1'b0};
                  count++;
                  scale = (scale * (255 - a) + 127) / 255;
                  layer--;
               end
               // leftover coverage goes to the bottom layer
               if (scale > SCALE_THRESH) begin
                  w = (scale * 255 + 32768) >> 16;
                  walk[count] = '{layer: '0, value: ALPHA_W'(w), visible: '0, is_last: 1'b0};
                  count++;
               end
               walk[count-1].visible = COUNT_W'(count);
               walk[count-1].is_last = 1'b1;
               for (k = 0; k < count; k++) answer_queue = {answer_queue, walk[k]};
            end
         end
         default: ;
      endcase
   endtask

   // watch all three channels at the rising edge
   always @(posedge clock) begin : watch
      answer_type got, want;
      if (reset) begin
         foreach (alpha_mirror[i]) alpha_mirror[i] = '0;
         count_mirror = 4'd1;
         answer_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.layer   = rsp_out_layer;
            got.value   = rsp_out_value;
            got.visible = rsp_visible_count;
            got.is_last = rsp_last;
            if (answer_queue.size() == 0) begin
               if (errors_seen < 10)
                  $display("unexpected result: layer %0d value %0d visible %0d last %0d",
                           got.layer, got.value, got.visible, got.is_last);
               errors_seen++;
            end else begin
               want = answer_queue.pop_front();
               if (got.layer !== want.layer || got.value !== want.value ||
                   got.visible !== want.visible || got.is_last !== want.is_last) begin
                  if (errors_seen < 10)
                     $display("mismatch: expected layer %0d value %0d visible %0d last %0d, %s",
                              want.layer, want.value, want.visible, want.is_last,
                              $sformatf("got layer %0d value %0d visible %0d last %0d",
                                        got.layer, got.value, got.visible, got.is_last));
                  errors_seen++;
               end
            end
         end
         if (csr_valid && csr_ready) count_mirror = csr_layer_count;
         if (req_valid && !req_stall)
            blend_item(req_operation, req_pos_x, req_pos_y, req_layer_sel, req_alpha_in);
      end
      error_total <= errors_seen;
      answers_due <= answer_queue.size();
   end

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
   import lbw_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 64;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation;
   logic [COORD_W-1:0]  req_pos_x;
   logic [COORD_W-1:0]  req_pos_y;
   logic [LAYER_W-1:0]  req_layer_sel;
   logic [ALPHA_W-1:0]  req_alpha_in;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [LAYER_W-1:0]  rsp_out_layer;
   logic [ALPHA_W-1:0]  rsp_out_value;
   logic [COUNT_W-1:0]  rsp_visible_count;
   logic                rsp_last;
   logic                csr_valid;
   logic                csr_ready;
   logic [COUNT_W-1:0]  csr_layer_count;
   int                  error_total;
   int                  answers_due;
   int                  cycle_count;
   int                  active_count;

   layer_blend_weight_store_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_layer_sel     (req_layer_sel),
      .req_alpha_in      (req_alpha_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_layer     (rsp_out_layer),
      .rsp_out_value     (rsp_out_value),
      .rsp_visible_count (rsp_visible_count),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_layer_count   (csr_layer_count)
   );

   layer_blend_weight_checker checker_i (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_layer_sel     (req_layer_sel),
      .req_alpha_in      (req_alpha_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_layer     (rsp_out_layer),
      .rsp_out_value     (rsp_out_value),
      .rsp_visible_count (rsp_visible_count),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_layer_count   (csr_layer_count),
      .error_total       (error_total),
      .answers_due       (answers_due)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit, covers the clearing sweep after reset
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // receiver stall pattern, switching between four random modes
   initial begin : stall_pattern
      int mode, span, tick;
      rsp_stall = 1'b0;
      tick = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 80);
         repeat (span) begin
            @(negedge clock);
            tick++;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 2) == 0);
               2: rsp_stall <= ((tick % 6) >= 4);
               default: rsp_stall <= ($urandom_range(0, 9) != 0);
            endcase
         end
      end
   end

   // offer one item and hold it until accepted
   task automatic push_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] px,
                            input logic [COORD_W-1:0] py, input logic [LAYER_W-1:0] sel,
                            input logic [ALPHA_W-1:0] alpha);
      @(negedge clock);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_pos_x     <= px;
      req_pos_y     <= py;
      req_layer_sel <= sel;
      req_alpha_in  <= alpha;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic rest_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain_answers();
      rest_sender(1);
      while (answers_due != 0) @(negedge clock);
   endtask

   // change the layer count once the block has gone quiet
   task automatic write_layer_count(input logic [COUNT_W-1:0] count);
      drain_answers();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_valid       <= 1'b1;
      csr_layer_count <= count;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      active_count = (count > 4'd8) ? 8 : int'(count);
   endtask

   // random item, mostly on a few hot pixels so the walks get deep
   task automatic random_item();
      int                 pick;
      logic [OP_W-1:0]    op;
      logic [COORD_W-1:0] px, py;
      logic [LAYER_W-1:0] sel;
      logic [ALPHA_W-1:0] alpha;
      pick = $urandom_range(0, 99);
      if (pick < 48) op = OP_WRITE;
      else if (pick < 66) op = OP_READ;
      else if (pick < 95) op = OP_QUERY;
      else op = OP_UNUSED;
      if ($urandom_range(0, 4) != 0) begin
         px = COORD_W'($urandom_range(0, 3) * 21);
         py = $urandom_range(0, 1) ? 6'd63 : 6'd0;
      end else begin
         px = COORD_W'($urandom_range(0, 63));
         py = COORD_W'($urandom_range(0, 63));
      end
      if (active_count > 0 && $urandom_range(0, 3) != 0)
         sel = LAYER_W'($urandom_range(0, active_count - 1));
      else
         sel = LAYER_W'($urandom_range(0, 7));
      pick = $urandom_range(0, 9);
      if (pick < 4) alpha = ALPHA_W'($urandom_range(0, 40));
      else if (pick == 4) alpha = 8'd0;
      else if (pick == 5) alpha = 8'd255;
      else alpha = ALPHA_W'($urandom_range(0, 255));
      push_item(op, px, py, sel, alpha);
   endtask

   // bursts of items with random gaps, optionally draining halfway
   task automatic random_phase(input int items, input bit pause_midway);
      int sent, burst, k;
      sent = 0;
      while (sent < items) begin
         burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         for (k = 0; k < burst && sent < items; k++) begin
            random_item();
            sent++;
            if (pause_midway && sent == items / 2) drain_answers();
         end
         if ($urandom_range(0, 3) != 0) rest_sender($urandom_range(1, 10));
      end
   endtask

   // main sequence
   initial begin : stimulus
      logic [COUNT_W-1:0] phase_counts [8];
      int p;
      phase_counts = '{4'd8, 4'd3, 4'd1, 4'd15, 4'd0, 4'd6, 4'd8, 4'd2};
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = '0;
      req_pos_x       = '0;
      req_pos_y       = '0;
      req_layer_sel   = '0;
      req_alpha_in    = '0;
      csr_valid       = 1'b0;
      csr_layer_count = '0;
      active_count    = 1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single layer after reset: leftover only, ignored layer, unused code
      push_item(OP_QUERY, 6'd10, 6'd20, 3'd0, 8'd0);
      push_item(OP_WRITE, 6'd63, 6'd63, 3'd0, 8'd255);
      push_item(OP_READ, 6'd63, 6'd63, 3'd0, 8'd0);
      push_item(OP_WRITE, 6'd63, 6'd63, 3'd5, 8'd77);
      push_item(OP_READ, 6'd63, 6'd63, 3'd5, 8'd0);
      push_item(OP_UNUSED, 6'd63, 6'd0, 3'd7, 8'd255);
      push_item(OP_QUERY, 6'd63, 6'd63, 3'd0, 8'd0);

      // full stack: opaque top, partial stack, empty stack
      write_layer_count(4'd8);
      push_item(OP_WRITE, 6'd1, 6'd2, 3'd7, 8'd255);
      push_item(OP_QUERY, 6'd1, 6'd2, 3'd0, 8'd0);
      push_item(OP_WRITE, 6'd3, 6'd4, 3'd7, 8'd128);
      push_item(OP_WRITE, 6'd3, 6'd4, 3'd6, 8'd200);
      push_item(OP_WRITE, 6'd3, 6'd4, 3'd5, 8'd10);
      push_item(OP_QUERY, 6'd3, 6'd4, 3'd0, 8'd0);
      push_item(OP_QUERY, 6'd5, 6'd5, 3'd0, 8'd0);
      push_item(OP_READ, 6'd3, 6'd4, 3'd7, 8'd0);
      push_item(OP_WRITE, 6'd0, 6'd0, 3'd4, 8'd0);
      push_item(OP_READ, 6'd1, 6'd2, 3'd7, 8'd0);

      // no layers in use
      write_layer_count(4'd0);
      push_item(OP_QUERY, 6'd3, 6'd4, 3'd0, 8'd0);
      push_item(OP_READ, 6'd63, 6'd63, 3'd0, 8'd0);
      push_item(OP_WRITE, 6'd0, 6'd0, 3'd0, 8'd9);

      // oversize count clamps, stored alphas kept
      write_layer_count(4'd15);
      push_item(OP_QUERY, 6'd3, 6'd4, 3'd0, 8'd0);
      push_item(OP_READ, 6'd63, 6'd63, 3'd0, 8'd0);

      // random phases over several layer counts
      for (p = 0; p < 8; p++) begin
         write_layer_count(phase_counts[p]);
         random_phase(38, p == 1);
      end

      drain_answers();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_total == 0 && answers_due == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
+incdir+design
design/lbw_pkg.sv
design/lbw_alpha_mem.sv
design/lbw_blend_unit.sv
design/layer_blend_weight_store_core.sv
tb/layer_blend_weight_checker.sv
tb/tb.sv
